>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int KEY_W       = 31;
    localparam int PORT_TAG_W  = 32;
    localparam int OCC_W       = 5;
    localparam int DEF_DEPTH   = 16;
    localparam int DEF_TAG_BITS = 32;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_STOPPED = 2'd3
    } status_t;

    // Broadcast to every cell of the chain in the cycle a beat is taken.
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } spq_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire spq_ctrl_t           ctrl,
    input  wire logic [KEY_W-1:0]    new_key,
    input  wire logic [TAG_BITS-1:0] new_tag,
    input  wire logic                left_ins,
    input  wire logic                left_valid,
    input  wire logic [KEY_W-1:0]    left_key,
    input  wire logic [TAG_BITS-1:0] left_tag,
    input  wire logic                right_valid,
    input  wire logic [KEY_W-1:0]    right_key,
    input  wire logic [TAG_BITS-1:0] right_tag,
    output logic                     ins,
    output logic                     valid,
    output logic [KEY_W-1:0]         key,
    output logic [TAG_BITS-1:0]      tag
);

    logic                valid_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [TAG_BITS-1:0] tag_reg;

    // The new entry belongs at or before this cell unless this cell holds an
    // entry whose key is less than or equal to it; equal keys stay in front.
    assign ins   = !(valid_reg && (key_reg <= new_key));
    assign valid = valid_reg;
    assign key   = key_reg;
    assign tag   = tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.flush) begin
            valid_reg <= 1'b0;
        end else if (ctrl.pop) begin
            valid_reg <= right_valid;
        end else if (ctrl.push && ins) begin
            valid_reg <= left_ins ? left_valid : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            key_reg <= right_key;
            tag_reg <= right_tag;
        end else if (ctrl.push && ins) begin
            if (left_ins) begin
                key_reg <= left_key;
                tag_reg <= left_tag;
            end else begin
                key_reg <= new_key;
                tag_reg <= new_tag;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                              Beat
// s_        in         s_command, s_item_key, s_item_tag                  one command
// m_        out        m_status, m_out_key, m_out_tag, m_occupancy        one result
//
// All cells of the chain compare their key with the pushed key at once; a push
// or pop shifts cells by one place, so a beat may enter every cycle while the
// output is not stalled; each result is in the output register from the next cycle.
// Synchronous active-low reset empties the queue and clears the stopped flag.
// A stalled result holds the output register; s_ready then follows m_ready.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH    = DEF_DEPTH,
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_command,
    input  wire logic [KEY_W-1:0]      s_item_key,
    input  wire logic [PORT_TAG_W-1:0] s_item_tag,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_status,
    output logic [KEY_W-1:0]           m_out_key,
    output logic [PORT_TAG_W-1:0]      m_out_tag,
    output logic [OCC_W-1:0]           m_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    // Cell outputs, one element per cell, each read at its own fixed place.
    logic [DEPTH-1:0]    cell_ins;
    logic [DEPTH-1:0]    cell_valid;
    logic [KEY_W-1:0]    cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];

    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;
    logic [PORT_TAG_W-1:0] m_tag_reg, m_tag_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                stopped_reg, stopped_next;

    logic                s_fire;
    cmd_t                cmd;
    spq_ctrl_t           ctrl;
    logic                full, empty;
    logic [63:0]         tag_in_wide;
    logic [TAG_BITS-1:0] tag_in;
    logic [63:0]         head_tag_wide;
    logic [31:0]         cnt_wide;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_command);

    // The valid cells always form a run from the head, so the last cell tells
    // whether the queue is full and the first whether it is empty.
    assign full  = cell_valid[DEPTH-1];
    assign empty = !cell_valid[0];

    assign tag_in_wide   = 64'(s_item_tag);
    assign tag_in        = tag_in_wide[TAG_BITS-1:0];
    assign head_tag_wide = 64'(cell_tag[0]);

    // A rejected push or pop leaves the chain untouched, so no control strobe
    // is raised for it.
    always_comb begin
        ctrl.push  = s_fire && (cmd == CMD_PUSH) && !full;
        ctrl.pop   = s_fire && (cmd == CMD_POP) && !stopped_reg && !empty;
        ctrl.flush = s_fire && (cmd == CMD_FLUSH);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                l_ins, l_valid, r_valid;
            logic [KEY_W-1:0]    l_key, r_key;
            logic [TAG_BITS-1:0] l_tag, r_tag;

            if (gi == 0) begin : g_head
                // Nothing lies ahead of the head: it takes the new entry itself.
                assign l_ins   = 1'b0;
                assign l_valid = 1'b0;
                assign l_key   = '0;
                assign l_tag   = '0;
            end else begin : g_body
                assign l_ins   = cell_ins[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_tag   = cell_tag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                // The tail empties on a pop.
                assign r_valid = 1'b0;
                assign r_key   = '0;
                assign r_tag   = '0;
            end else begin : g_inner
                assign r_valid = cell_valid[gi+1];
                assign r_key   = cell_key[gi+1];
                assign r_tag   = cell_tag[gi+1];
            end

            spq_cell #(
                .TAG_BITS(TAG_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_key    (s_item_key),
                .new_tag    (tag_in),
                .left_ins   (l_ins),
                .left_valid (l_valid),
                .left_key   (l_key),
                .left_tag   (l_tag),
                .right_valid(r_valid),
                .right_key  (r_key),
                .right_tag  (r_tag),
                .ins        (cell_ins[gi]),
                .valid      (cell_valid[gi]),
                .key        (cell_key[gi]),
                .tag        (cell_tag[gi])
            );
        end
    endgenerate

    // Result register, occupancy count and stopped flag.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_tag_next    = m_tag_reg;
        cnt_next      = cnt_reg;
        stopped_next  = stopped_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            m_valid_next  = 1'b1;
            m_status_next = ST_OK;
            m_key_next    = '0;
            m_tag_next    = '0;
            case (cmd)
                CMD_PUSH: begin
                    if (full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                CMD_POP: begin
                    if (stopped_reg) begin
                        m_status_next = ST_STOPPED;
                    end else if (empty) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        m_key_next = cell_key[0];
                        m_tag_next = head_tag_wide[PORT_TAG_W-1:0];
                        cnt_next   = cnt_reg - CW'(1);
                    end
                end
                CMD_STOP: begin
                    stopped_next = 1'b1;
                end
                CMD_FLUSH: begin
                    cnt_next = '0;
                end
                default: begin
                    m_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

    // The occupancy field carries the count after the beat's command.
    logic [CW-1:0] m_occ_reg;

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_tag_reg    <= m_tag_next;
        if (s_fire) begin
            m_occ_reg <= cnt_next;
        end
    end

    assign cnt_wide    = 32'(m_occ_reg);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_key   = m_key_reg;
    assign m_out_tag   = m_tag_reg;
    assign m_occupancy = cnt_wide[OCC_W-1:0];

    // The count register always agrees with the cells that hold an entry.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) == $countones(cell_valid))
        else $error("occupancy count disagrees with the cell valid bits");

    // Held entries form one unbroken run from the head.
    a_valid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("valid cells do not form a run from the head");

    // A successful pop shortens the queue by exactly one.
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |=> (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("pop did not remove exactly one entry");

    // A pop reported empty leaves the queue empty.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_EMPTY)) |-> (m_occ_reg == '0))
        else $error("empty status with entries held");

    // A refused push never changes the occupancy count.
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (cmd == CMD_PUSH) && full) |=> (cnt_reg == $past(cnt_reg)))
        else $error("push to a full queue changed the occupancy");

endmodule

`default_nettype wire

>>> tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

// The queue is driven with push, pop, stop and flush commands on its input
// channel, and every result beat is checked against a software copy of the
// queue that is kept in step with the commands the block has accepted.
// Both channels idle at random. The receiver once holds off long enough for
// the block to back up and stall its input. The sender once waits until the
// queue has answered everything before it carries on.
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int DEPTH    = DEF_DEPTH;
    localparam int TAG_BITS = DEF_TAG_BITS;
    localparam logic [PORT_TAG_W-1:0] TAG_MASK =
        {PORT_TAG_W{1'b1}} >> (PORT_TAG_W - TAG_BITS);
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    // Phase lengths, counted in accepted commands.
    localparam int MAIN_ITEMS   = 1000;
    localparam int TOTAL_ITEMS  = 1150;
    localparam int PAUSE_AFTER  = 600;
    // Result count at which the receiver holds off for a long stretch.
    localparam int LONG_HOLD_AT = 250;
    localparam int LONG_HOLD    = 80;

    // One result beat as the queue should present it.
    typedef struct packed {
        status_t               status;
        logic [KEY_W-1:0]      key;
        logic [PORT_TAG_W-1:0] tag;
        logic [OCC_W-1:0]      occupancy;
    } spq_result_t;

    // Keeps its own sorted copy of the queue and the stop flag, and turns
    // every accepted command into the result that the block owes for it.
    class queue_scoreboard;
        logic [KEY_W-1:0]      held_keys[$];
        logic [PORT_TAG_W-1:0] held_tags[$];
        bit                    halted;
        spq_result_t           due_results[$];
        int failures;
        int checked;
        int n_push, n_pop, n_stop, n_flush;
        int n_full, n_empty, n_refused;

        function void note_command(cmd_t cmd, logic [KEY_W-1:0] key,
                                   logic [PORT_TAG_W-1:0] tag);
            spq_result_t res;
            int pos;
            res = '{status: ST_OK, key: '0, tag: '0, occupancy: '0};
            case (cmd)
                CMD_PUSH: begin
                    n_push++;
                    if (held_keys.size() >= DEPTH) begin
                        res.status = ST_FULL;
                        n_full++;
                    end else begin
                        // A new entry goes behind every entry whose key is
                        // not greater, so equal keys keep arrival order.
                        pos = 0;
                        while (pos < held_keys.size() && held_keys[pos] <= key)
                            pos++;
                        held_keys.insert(pos, key);
                        held_tags.insert(pos, tag & TAG_MASK);
                    end
                end
                CMD_POP: begin
                    n_pop++;
                    if (halted) begin
                        res.status = ST_STOPPED;
                        n_refused++;
                    end else if (held_keys.size() == 0) begin
                        res.status = ST_EMPTY;
                        n_empty++;
                    end else begin
                        res.key = held_keys.pop_front();
                        res.tag = held_tags.pop_front();
                    end
                end
                CMD_STOP: begin
                    n_stop++;
                    halted = 1'b1;
                end
                default: begin
                    // Flush drops every entry but leaves the stop flag alone.
                    n_flush++;
                    held_keys.delete();
                    held_tags.delete();
                end
            endcase
            res.occupancy = OCC_W'(held_keys.size());
            due_results.push_back(res);
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            failures++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_result(logic [1:0] status, logic [KEY_W-1:0] key,
                                   logic [PORT_TAG_W-1:0] tag,
                                   logic [OCC_W-1:0] occupancy);
            spq_result_t want;
            checked++;
            if (due_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result beat: status %0d key %h tag %h occupancy %0d",
                         $time, status, key, tag, occupancy);
                return;
            end
            want = due_results.pop_front();
            if (status !== want.status)
                flag("status", 64'(want.status), 64'(status));
            if (key !== want.key)
                flag("out_key", 64'(want.key), 64'(key));
            if (tag !== want.tag)
                flag("out_tag", 64'(want.tag), 64'(tag));
            if (occupancy !== want.occupancy)
                flag("occupancy", 64'(want.occupancy), 64'(occupancy));
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command   = CMD_PUSH;
    logic [KEY_W-1:0]      s_item_key  = '0;
    logic [PORT_TAG_W-1:0] s_item_tag  = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_status;
    logic [KEY_W-1:0]      m_out_key;
    logic [PORT_TAG_W-1:0] m_out_tag;
    logic [OCC_W-1:0]      m_occupancy;

    queue_scoreboard sb = new();

    // When set, the sender offers beats back to back without idling.
    bit tx_quiet;
    int n_sent;

    sorted_priority_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_item_key  (s_item_key),
        .s_item_tag  (s_item_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_key   (m_out_key),
        .m_out_tag   (m_out_tag),
        .m_occupancy (m_occupancy)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Keys are drawn so that ties, the extremes and wide random values all
    // turn up often; small keys give plenty of equal-key entries.
    function automatic logic [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 7));
            1:       return KEY_W'($urandom);
            2:       return ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
            default: return KEY_MAX - KEY_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [PORT_TAG_W-1:0] draw_tag();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? {PORT_TAG_W{1'b1}} : '0;
        return $urandom;
    endfunction

    // Offers one command beat, after a random gap unless the sender is in a
    // quiet stretch, and holds it steady until the block takes it. Called at
    // a rising edge and returns at the edge where the beat was accepted.
    task automatic offer(cmd_t cmd, logic [KEY_W-1:0] key, logic [PORT_TAG_W-1:0] tag);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_item_key <= key;
        s_item_tag <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(cmd, key, tag);
        n_sent++;
    endtask

    // Draws a command with the given share of pushes; the rest are mostly
    // pops with the odd flush, and stops only once they are allowed.
    task automatic random_command(int push_pct, bit allow_stop);
        int   roll;
        cmd_t cmd;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            cmd = CMD_PUSH;
        else if (roll < 96)
            cmd = CMD_POP;
        else if (roll < 98)
            cmd = allow_stop ? CMD_STOP : CMD_POP;
        else
            cmd = CMD_FLUSH;
        offer(cmd, draw_key(), draw_tag());
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.due_results.size() != 0) @(posedge aclk);
    endtask

    // Sender: reset, then directed commands, then random sequences, and the
    // stop flag only towards the end since it can never be cleared again.
    initial begin
        int  kind;
        int  len;
        int  pct;
        bit  paused;
        paused   = 1'b0;
        tx_quiet = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pop and flush on an empty queue.
        offer(CMD_POP,   '0, '0);
        offer(CMD_FLUSH, draw_key(), draw_tag());
        // Extreme keys and tags, then three equal keys that must leave in
        // the order in which they arrived.
        offer(CMD_PUSH, KEY_MAX, {PORT_TAG_W{1'b1}});
        offer(CMD_PUSH, '0, '0);
        offer(CMD_PUSH, KEY_W'(5), 32'hA5A5_A5A5);
        offer(CMD_PUSH, KEY_W'(5), 32'h5A5A_5A5A);
        offer(CMD_PUSH, KEY_W'(5), 32'h0000_0001);
        repeat (5) offer(CMD_POP, draw_key(), draw_tag());
        // One pop too many.
        offer(CMD_POP, KEY_MAX, {PORT_TAG_W{1'b1}});
        // Flush of a queue that holds entries.
        offer(CMD_PUSH, KEY_W'(32'h4000_0000), 32'h8000_0000);
        offer(CMD_PUSH, KEY_W'(1), 32'h7FFF_FFFF);
        offer(CMD_FLUSH, '0, '0);
        offer(CMD_POP, '0, '0);

        // Overfill the queue so that the last pushes are refused as full.
        tx_quiet = 1'b1;
        repeat (DEPTH + 2) offer(CMD_PUSH, draw_key(), draw_tag());

        // Random sequences: push-heavy runs that reach the full state,
        // pop-heavy runs that reach empty, mixed runs and lone flushes.
        while (n_sent < MAIN_ITEMS) begin
            kind     = $urandom_range(0, 9);
            tx_quiet = ($urandom_range(0, 3) == 0);
            len      = $urandom_range(4, 20);
            if (kind == 9) begin
                offer(CMD_FLUSH, draw_key(), draw_tag());
            end else begin
                pct = (kind < 4) ? 85 : (kind < 7) ? 15 : 50;
                repeat (len) random_command(pct, 1'b0);
            end
            // Once in the run the sender lets the block go fully idle.
            if (!paused && n_sent > PAUSE_AFTER) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // Stop: a pop on a held entry is refused, pushes still land, a
        // second stop is harmless, and a flush keeps the flag.
        tx_quiet = 1'b0;
        offer(CMD_PUSH, KEY_W'(9), 32'h0BAD_F00D);
        offer(CMD_STOP, draw_key(), draw_tag());
        offer(CMD_POP,  draw_key(), draw_tag());
        offer(CMD_PUSH, KEY_W'(3), 32'h1234_5678);
        offer(CMD_STOP, draw_key(), draw_tag());
        offer(CMD_FLUSH, draw_key(), draw_tag());
        offer(CMD_POP,  '0, '0);

        // Random tail with the flag set: the queue fills up and is flushed.
        while (n_sent < TOTAL_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            pct      = $urandom_range(30, 70);
            repeat ($urandom_range(4, 20)) random_command(pct, 1'b1);
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Ran %0d commands: %0d pushes, %0d pops, %0d stops, %0d flushes.",
                 n_sent, sb.n_push, sb.n_pop, sb.n_stop, sb.n_flush);
        $display("Pushes to a full queue %0d, pops when empty %0d, pops after stop %0d.",
                 sb.n_full, sb.n_empty, sb.n_refused);
        if (sb.failures == 0 && sb.due_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: takes result beats after random stalls, with stretches of no
    // stalling, and once holds off long enough for the input to back up.
    initial begin
        int n_received;
        int stall;
        bit rx_quiet;
        n_received = 0;
        rx_quiet   = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (n_received % 97 == 96)
                rx_quiet = !rx_quiet;
            if (n_received == LONG_HOLD_AT)
                stall = LONG_HOLD;
            else
                stall = rx_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid === 1'b1 && m_ready)) @(posedge aclk);
            sb.check_result(m_status, m_out_key, m_out_tag, m_occupancy);
            n_received++;
        end
    end

    // Guards against a hang: far longer than the slowest legal run needs.
    initial begin
        #2_000_000;
        $display("%0t: timed out with %0d results outstanding", $time,
                 sb.due_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
